/* rtl/skvt_pkg.sv */
// shared types and constants for the sorted key/value table
package skvt_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 16;
    localparam int VALUE_W      = 8;
    localparam int COUNT_OUT_W  = 5;
    localparam int RESULT_LIMIT = 16;
    localparam int RES_CNT_W    = $clog2(RESULT_LIMIT);

    // item actions
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_DELETE = 2'd3
    } t_action;

    // result status codes
    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_MISSING = 2'd1,
        STS_FULL    = 2'd2,
        STS_EMPTY   = 2'd3
    } t_status;

    // command broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_DELETE = 3'd2,
        CELL_UPDATE = 3'd3,
        CELL_MARK   = 3'd4,
        CELL_PICK   = 3'd5
    } t_cell_op;

    // controller states
    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_EXEC = 2'd1,
        FSM_LOOK = 2'd2
    } t_fsm;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_entry;

    typedef struct packed {
        t_cell_op           op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_cell_cmd;

    // status handed from one cell to its right neighbour
    typedef struct packed {
        logic occ;   // cell holds a live entry
        logic gt;    // live entry key above the command key
        logic seen;  // a flagged cell exists at or left of this one
    } t_link;

endpackage

/* rtl/skvt_cell.sv */
// one cell of the table: a key/value entry plus a lookup pending flag
module skvt_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  skvt_pkg::t_cell_cmd            i_cmd,
    input  logic                           i_occ,
    input  logic                           i_is_tail,
    input  skvt_pkg::t_link                i_link,
    input  skvt_pkg::t_entry               i_left,
    input  skvt_pkg::t_entry               i_right,
    input  logic [skvt_pkg::KEY_W-1:0]     i_head_key,
    output skvt_pkg::t_link                o_link,
    output skvt_pkg::t_entry               o_entry,
    output logic                           o_eq,
    output logic                           o_pick,
    output logic                           o_pend_left,
    output skvt_pkg::t_entry               o_pick_data
);
    import skvt_pkg::*;

    t_entry             r_entry, n_entry;
    logic               r_pend, n_pend;
    logic               w_eq, w_gt, w_flag, w_pick;
    logic [KEY_W-1:0]   w_next_key;

    // key compare against the broadcast key
    assign w_eq   = i_occ && (r_entry.key == i_cmd.key);
    assign w_gt   = i_occ && (r_entry.key > i_cmd.key);
    assign w_flag = (i_cmd.op == CELL_PICK) ? r_pend : w_eq;
    assign w_pick = (i_cmd.op == CELL_PICK) && r_pend && !i_link.seen;

    // neighbour link and result tap
    assign w_next_key  = i_is_tail ? i_head_key : i_right.key;
    assign o_link      = '{occ: i_occ, gt: w_gt, seen: i_link.seen | w_flag};
    assign o_entry     = r_entry;
    assign o_eq        = w_eq;
    assign o_pick      = w_pick;
    assign o_pend_left = r_pend && !w_pick;
    assign o_pick_data = w_pick ? t_entry'{key: w_next_key, value: r_entry.value} : '0;

    // next entry and pending flag
    always_comb begin
        n_entry = r_entry;
        n_pend  = r_pend;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (i_link.gt) begin
                    n_entry = i_left;
                end else if (i_link.occ && (w_gt || !i_occ)) begin
                    n_entry = '{key: i_cmd.key, value: i_cmd.value};
                end
            end
            CELL_DELETE: begin
                if (i_link.seen || w_eq) begin
                    n_entry = i_right;
                end
            end
            CELL_UPDATE: begin
                if (w_eq && !i_link.seen) begin
                    n_entry.value = i_cmd.value;
                end
            end
            CELL_MARK: begin
                n_pend = w_eq;
            end
            CELL_PICK: begin
                if (w_pick) begin
                    n_pend = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // entry storage, no reset
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // pending flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= n_pend;
        end
    end

endmodule

/* rtl/sorted_key_value_table.sv */
// Sorted key/value table built from a row of compare-and-shift cells.
// Flow: the accepted item is registered, then EXEC registers its result once the output
// is free; a lookup hit goes on to LOOK, one result per cycle while the output is not
// held, via the single output register fed by the cell row; ready only in IDLE.
// Reset: entry count and control cleared; entry contents undefined, no clearing pass.
module sorted_key_value_table #(
    parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_action,
    input  logic [skvt_pkg::KEY_W-1:0]         i_key,
    input  logic [skvt_pkg::VALUE_W-1:0]       i_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_status,
    output logic [skvt_pkg::VALUE_W-1:0]       o_found_value,
    output logic [skvt_pkg::KEY_W-1:0]         o_next_key,
    output logic [skvt_pkg::COUNT_OUT_W-1:0]   o_entry_count,
    output logic                               o_last
);
    import skvt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_fsm                   r_state, n_state;
    t_action                r_action;
    logic [KEY_W-1:0]       r_key;
    logic [VALUE_W-1:0]     r_value;
    logic [CW-1:0]          r_count, n_count;
    logic [RES_CNT_W-1:0]   r_nres, n_nres;

    logic                   r_out_valid, n_out_valid;
    t_status                r_status, n_status;
    logic [VALUE_W-1:0]     r_found_value, n_found_value;
    logic [KEY_W-1:0]       r_next_key, n_next_key;
    logic [COUNT_OUT_W-1:0] r_out_count, n_out_count;
    logic                   r_last, n_last;

    t_cell_cmd              w_cmd;
    t_link                  w_link [CAPACITY+1];
    t_entry                 w_entry [CAPACITY];
    t_entry                 w_pick_data [CAPACITY];
    logic [CAPACITY-1:0]    w_eq, w_pick, w_pend_left;
    t_entry                 w_sel;
    logic                   w_any_eq, w_any_left, w_out_free, w_accept;

    assign w_link[0]  = '{occ: 1'b1, gt: 1'b0, seen: 1'b0};
    assign w_out_free = !r_out_valid || i_ready;
    assign w_accept   = i_valid && o_ready;

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        skvt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_occ       (r_count > CW'(g)),
            .i_is_tail   (r_count == CW'(g + 1)),
            .i_link      (w_link[g]),
            .i_left      (w_entry[(g == 0) ? 0 : g - 1]),
            .i_right     (w_entry[(g == CAPACITY - 1) ? g : g + 1]),
            .i_head_key  (w_entry[0].key),
            .o_link      (w_link[g+1]),
            .o_entry     (w_entry[g]),
            .o_eq        (w_eq[g]),
            .o_pick      (w_pick[g]),
            .o_pend_left (w_pend_left[g]),
            .o_pick_data (w_pick_data[g])
        );
    end

    // gather picked entry and match flags
    always_comb begin
        w_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_sel = w_sel | w_pick_data[i];
        end
        w_any_eq   = |w_eq;
        w_any_left = |w_pend_left;
    end

    // controller: next state, cell command and result
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_nres        = r_nres;
        n_out_valid   = r_out_valid && !i_ready;
        n_status      = r_status;
        n_found_value = r_found_value;
        n_next_key    = r_next_key;
        n_out_count   = r_out_count;
        n_last        = r_last;
        w_cmd         = '{op: CELL_HOLD, key: r_key, value: r_value};
        o_ready       = 1'b0;
        unique case (r_state)
            FSM_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (w_out_free) begin
                    n_state       = FSM_IDLE;
                    n_out_valid   = 1'b1;
                    n_status      = STS_OK;
                    n_found_value = '0;
                    n_next_key    = '0;
                    n_last        = 1'b1;
                    if (r_action == ACT_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = STS_FULL;
                        end else begin
                            w_cmd.op = CELL_INSERT;
                            n_count  = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_status = STS_EMPTY;
                    end else if (!w_any_eq) begin
                        n_status = STS_MISSING;
                    end else if (r_action == ACT_LOOKUP) begin
                        w_cmd.op    = CELL_MARK;
                        n_state     = FSM_LOOK;
                        n_nres      = '0;
                        n_out_valid = r_out_valid && !i_ready;
                    end else if (r_action == ACT_UPDATE) begin
                        w_cmd.op = CELL_UPDATE;
                    end else begin
                        w_cmd.op = CELL_DELETE;
                        n_count  = r_count - CW'(1);
                    end
                    n_out_count = COUNT_OUT_W'(n_count);
                end
            end
            FSM_LOOK: begin
                if (w_out_free) begin
                    w_cmd.op      = CELL_PICK;
                    n_out_valid   = 1'b1;
                    n_status      = STS_OK;
                    n_found_value = w_sel.value;
                    n_next_key    = w_sel.key;
                    n_out_count   = COUNT_OUT_W'(r_count);
                    n_last        = !w_any_left || (r_nres == RES_CNT_W'(RESULT_LIMIT - 1));
                    n_nres        = r_nres + RES_CNT_W'(1);
                    if (n_last) begin
                        n_state = FSM_IDLE;
                    end
                end
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FSM_IDLE;
            r_count     <= '0;
            r_nres      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_nres      <= n_nres;
            r_out_valid <= n_out_valid;
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= t_action'(i_action);
            r_key    <= i_key;
            r_value  <= i_value;
        end
        r_status      <= n_status;
        r_found_value <= n_found_value;
        r_next_key    <= n_next_key;
        r_out_count   <= n_out_count;
        r_last        <= n_last;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_found_value = r_found_value;
    assign o_next_key    = r_next_key;
    assign o_entry_count = r_out_count;
    assign o_last        = r_last;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_pick_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_pick))
        else $error("more than one cell picked");

    a_look_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FSM_LOOK) |-> (|w_pend_left || |w_pick))
        else $error("lookup running with no pending match");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FSM_EXEC && w_out_free && r_action == ACT_INSERT
            && r_count != CW'(CAPACITY))
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the table");

endmodule
